@@ design/egzd_pkg.sv @@
// ----------------------------------------------------------------------------
// egzd_pkg
// Shared widths, state codes and types for the Elias gamma zigzag decoder.
// ----------------------------------------------------------------------------
package egzd_pkg;

  localparam int CODE_BITS = 32;
  localparam int RUN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 3;

  localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(CODE_BITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_BITS  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  typedef struct packed {
    logic                 reading;
    logic [RUN_W-1:0]     zero_run;
    logic [RUN_W-1:0]     digits_left;
    logic [CODE_BITS-1:0] acc;
  } dec_state_t;

  typedef struct packed {
    logic                        emit;
    logic                        err;
    logic signed [CODE_BITS-1:0] value;
  } step_t;

endpackage

@@ design/egzd_if.sv @@
// ----------------------------------------------------------------------------
// egzd_in_if / egzd_out_if
// Valid/ready channels for code bytes in and decoded values out.
// ----------------------------------------------------------------------------
interface egzd_in_if;
  logic                        valid;
  logic                        ready;
  logic [egzd_pkg::BYTE_W-1:0] data_byte;
  logic                        stream_start;

  modport source (output valid, output data_byte, output stream_start, input ready);
  modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

interface egzd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [egzd_pkg::CODE_BITS-1:0] decoded_value;
  logic                                  too_long;
  logic                                  last_of_byte;

  modport source (output valid, output decoded_value, output too_long,
                  output last_of_byte, input ready);
  modport sink (input valid, input decoded_value, input too_long,
                input last_of_byte, output ready);
endinterface

@@ design/elias_gamma_zigzag_decoder_top.sv @@
// ----------------------------------------------------------------------------
// elias_gamma_zigzag_decoder_top
// Byte-fed Elias gamma decoder, inverse zigzag, one bit/cycle unless stalled.
// ----------------------------------------------------------------------------
//   channel  dir  request
//   in_ch    in   data_byte, stream_start
//   out_ch   out  decoded_value, too_long, last_of_byte
//
// A byte passes through accept, eight bit steps through the shared bit unit
// and one flush of the held result. A bit step that finishes a value and
// the flush wait while out_ch holds a stalled result.
// A finished value is held until the next one or the flush, so that the last
// one of a byte can be marked. rst (synchronous) clears the decoder state
// and the sequencer. in_ch is ready only between bytes.
module elias_gamma_zigzag_decoder_top (
  input logic       clk,
  input logic       rst,
  egzd_in_if.sink   in_ch,
  egzd_out_if.source out_ch
);

  logic [1:0]                          state;
  logic [egzd_pkg::BYTE_W-1:0]         sr;
  logic [egzd_pkg::CNT_W-1:0]          cnt;
  egzd_pkg::dec_state_t                dec;
  egzd_pkg::dec_state_t                dec_next;
  egzd_pkg::step_t                     step;
  logic                                pv;
  logic signed [egzd_pkg::CODE_BITS-1:0] pval;
  logic                                perr;
  logic                                ov;
  logic signed [egzd_pkg::CODE_BITS-1:0] oval;
  logic                                oerr;
  logic                                olast;
  logic                                can_push;
  logic                                stall;
  logic                                out_load;

  egzd_bit_unit u_bit (
    .cur    (dec),
    .bit_in (sr[egzd_pkg::BYTE_W-1]),
    .nxt    (dec_next),
    .step   (step)
  );

  assign in_ch.ready          = (state == egzd_pkg::ST_IDLE);
  assign out_ch.valid         = ov;
  assign out_ch.decoded_value = oval;
  assign out_ch.too_long      = oerr;
  assign out_ch.last_of_byte  = olast;

  assign can_push = !ov || out_ch.ready;
  assign stall    = step.emit && pv && !can_push;
  assign out_load = (state == egzd_pkg::ST_BITS && !stall && step.emit && pv)
                 || (state == egzd_pkg::ST_FLUSH && pv && can_push);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egzd_pkg::ST_IDLE;
      cnt   <= '0;
      dec   <= '0;
      pv    <= 1'b0;
      ov    <= 1'b0;
    end else begin
      if (out_load) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        egzd_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            sr    <= in_ch.data_byte;
            cnt   <= '0;
            state <= egzd_pkg::ST_BITS;
            if (in_ch.stream_start) begin
              dec <= '0;
            end
          end
        end
        egzd_pkg::ST_BITS: begin
          if (!stall) begin
            dec <= dec_next;
            sr  <= sr << 1;
            cnt <= cnt + 1'b1;
            if (step.emit) begin
              if (pv) begin
                oval  <= pval;
                oerr  <= perr;
                olast <= 1'b0;
              end
              pv   <= 1'b1;
              pval <= step.value;
              perr <= step.err;
            end
            if (cnt == '1) begin
              state <= egzd_pkg::ST_FLUSH;
            end
          end
        end
        egzd_pkg::ST_FLUSH: begin
          if (!pv) begin
            state <= egzd_pkg::ST_IDLE;
          end else if (can_push) begin
            oval  <= pval;
            oerr  <= perr;
            olast <= 1'b1;
            pv    <= 1'b0;
            state <= egzd_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= egzd_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/egzd_bit_unit.sv @@
// ----------------------------------------------------------------------------
// egzd_bit_unit
// Advances the decoder state by one code bit and reports any finished value.
// ----------------------------------------------------------------------------
module egzd_bit_unit (
  input  egzd_pkg::dec_state_t cur,
  input  logic                 bit_in,
  output egzd_pkg::dec_state_t nxt,
  output egzd_pkg::step_t      step
);

  logic [egzd_pkg::RUN_W-1:0]     run_inc;
  logic [egzd_pkg::RUN_W-1:0]     dl_dec;
  logic [egzd_pkg::CODE_BITS-1:0] acc_sh;
  logic [egzd_pkg::CODE_BITS-1:0] half;

  assign run_inc = cur.zero_run + 1'b1;
  assign dl_dec  = cur.digits_left - 1'b1;
  assign acc_sh  = {cur.acc[egzd_pkg::CODE_BITS-2:0], bit_in};
  assign half    = acc_sh >> 1;

  always_comb begin
    nxt  = cur;
    step = '0;
    if (!cur.reading) begin
      if (!bit_in) begin
        if (run_inc >= egzd_pkg::RUN_LIMIT) begin
          nxt       = '0;
          step.emit = 1'b1;
          step.err  = 1'b1;
        end else begin
          nxt.zero_run = run_inc;
        end
      end else if (cur.zero_run == '0) begin
        step.emit = 1'b1;
      end else begin
        nxt.reading     = 1'b1;
        nxt.digits_left = cur.zero_run;
        nxt.acc         = egzd_pkg::CODE_BITS'(1);
      end
    end else begin
      nxt.acc         = acc_sh;
      nxt.digits_left = dl_dec;
      if (dl_dec == '0) begin
        nxt        = '0;
        step.emit  = 1'b1;
        step.value = acc_sh[0] ? half : (~half + 1'b1);
      end
    end
  end

endmodule

@@ design/egzd_checker.sv @@
// ----------------------------------------------------------------------------
// egzd_checker
// Port-level checks on the decoder top, attached by bind.
// ----------------------------------------------------------------------------
module egzd_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [egzd_pkg::CODE_BITS-1:0] decoded_value,
  input logic                                  too_long,
  input logic                                  last_of_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(decoded_value)
      && $stable(too_long) && $stable(last_of_byte))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> decoded_value == '0)
    else $error("error result carries a value");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a byte was taken");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (rst)
    in_ready && !out_valid |=> !out_valid)
    else $error("result appeared while idle");

endmodule

bind elias_gamma_zigzag_decoder_top egzd_checker u_egzd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .decoded_value (out_ch.decoded_value),
  .too_long      (out_ch.too_long),
  .last_of_byte  (out_ch.last_of_byte)
);

@@ tb/elias_gamma_zigzag_decoder_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elias_gamma_zigzag_decoder_top_test
// Sends packed Elias gamma code bytes and checks each decoded signed value,
// its overlong-prefix flag and its end-of-byte marker against a bit-serial
// decoder model kept in step with every accepted byte. Directed bytes cover
// eight codes in one byte, the overlong prefix, the extreme values, padding
// and a restart in the middle of a code. Random streams of well-formed codes
// follow, mixed with noise, long zero runs and broken codes, under random
// stalls on both channels.
// ----------------------------------------------------------------------------
module elias_gamma_zigzag_decoder_top_test;

  localparam int STREAM_BYTES  = 420;
  localparam int CALM_TAIL     = 60;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [egzd_pkg::BYTE_W-1:0] data_byte;
    logic                        stream_start;
    logic                        drain_first;
  } code_byte_t;

  typedef struct packed {
    logic signed [egzd_pkg::CODE_BITS-1:0] value;
    logic                                  too_long;
    logic                                  last_of_byte;
  } decoded_t;

  logic clk;
  logic rst;

  egzd_in_if  in_ch();
  egzd_out_if out_ch();

  elias_gamma_zigzag_decoder_top u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  code_byte_t byte_queue[$];
  bit         bit_stream[$];
  logic       start_next = 1'b0;
  logic       drain_next = 1'b0;
  decoded_t   expected_values[$];
  int         outstanding = 0;

  logic                           collecting_digits;
  logic [egzd_pkg::RUN_W-1:0]     zero_count;
  logic [egzd_pkg::RUN_W-1:0]     digits_owed;
  logic [egzd_pkg::CODE_BITS-1:0] code_word;

  int error_count     = 0;
  int bytes_sent      = 0;
  int restarts_seen   = 0;
  int values_checked  = 0;
  int overlong_seen   = 0;
  int cycle_count     = 0;
  int in_gap          = 0;
  int out_stall       = 0;
  logic draining      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_bits(input logic [31:0] bits, input int count);
    for (int i = count - 1; i >= 0; i--) bit_stream = {bit_stream, bits[i]};
  endtask

  task automatic push_code(input logic [egzd_pkg::CODE_BITS-1:0] k);
    int len;
    len = 1;
    for (int i = 0; i < egzd_pkg::CODE_BITS; i++) if (k[i]) len = i + 1;
    push_bits('0, len - 1);
    push_bits(k, len);
  endtask

  task automatic pack_bytes();
    code_byte_t b;
    while (bit_stream.size() >= 8) begin
      for (int i = 7; i >= 0; i--) b.data_byte[i] = bit_stream.pop_front();
      b.stream_start = start_next;
      b.drain_first  = drain_next;
      start_next     = 1'b0;
      drain_next     = 1'b0;
      byte_queue     = {byte_queue, b};
    end
  endtask

  task automatic pad_and_pack();
    while (bit_stream.size() % 8 != 0) bit_stream = {bit_stream, 1'b0};
    pack_bytes();
  endtask

  function automatic bit quiet_phase();
    return byte_queue.size() < CALM_TAIL || (bytes_sent / 64) % 4 == 3;
  endfunction

  task automatic restart_code();
    collecting_digits = 1'b0;
    zero_count        = '0;
    digits_owed       = '0;
    code_word         = '0;
  endtask

  task automatic decode_byte(input logic [egzd_pkg::BYTE_W-1:0] data, input logic restart);
    decoded_t                       found[$];
    decoded_t                       v;
    logic                           hit;
    logic [egzd_pkg::CODE_BITS-1:0] half;
    if (restart) restart_code();
    for (int pos = egzd_pkg::BYTE_W - 1; pos >= 0; pos--) begin
      hit = 1'b0;
      v   = '0;
      if (!collecting_digits) begin
        if (!data[pos]) begin
          zero_count = zero_count + 1'b1;
          if (zero_count >= egzd_pkg::CODE_BITS) begin
            restart_code();
            v.too_long = 1'b1;
            hit        = 1'b1;
          end
        end else if (zero_count == 0) begin
          hit = 1'b1;
        end else begin
          collecting_digits = 1'b1;
          digits_owed       = zero_count;
          code_word         = egzd_pkg::CODE_BITS'(1);
        end
      end else begin
        code_word   = {code_word[egzd_pkg::CODE_BITS-2:0], data[pos]};
        digits_owed = digits_owed - 1'b1;
        if (digits_owed == 0) begin
          half    = code_word >> 1;
          v.value = code_word[0] ? half : -half;
          restart_code();
          hit = 1'b1;
        end
      end
      if (hit) found = {found, v};
    end
    if (found.size() > 0) found[found.size() - 1].last_of_byte = 1'b1;
    foreach (found[i]) expected_values = {expected_values, found[i]};
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid        <= 1'b0;
      in_ch.data_byte    <= '0;
      in_ch.stream_start <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) bytes_sent++;
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (byte_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (byte_queue[0].drain_first && !draining) begin
        draining = 1'b1;
        in_ch.valid <= 1'b0;
      end else if (draining && outstanding != 0) begin
        // hold the request until every expected value has come back
        in_ch.valid <= 1'b0;
      end else begin
        draining = 1'b0;
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= byte_queue[0].data_byte;
        in_ch.stream_start <= byte_queue[0].stream_start;
        void'(byte_queue.pop_front());
        if (!quiet_phase() && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 14);
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      restart_code();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_values.size() == 0) begin
          error_count++;
          $display("%0t: unexpected value %0d too_long %0b last %0b", $time,
                   out_ch.decoded_value, out_ch.too_long, out_ch.last_of_byte);
        end else begin
          want = expected_values.pop_front();
          values_checked++;
          if (want.too_long) overlong_seen++;
          if (out_ch.decoded_value !== want.value || out_ch.too_long !== want.too_long ||
              out_ch.last_of_byte !== want.last_of_byte) begin
            error_count++;
            $display("%0t: mismatch: expected value %0d too_long %0b last %0b, got %0d %0b %0b",
                     $time, want.value, want.too_long, want.last_of_byte,
                     out_ch.decoded_value, out_ch.too_long, out_ch.last_of_byte);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.stream_start) restarts_seen++;
        decode_byte(in_ch.data_byte, in_ch.stream_start);
      end
      outstanding <= expected_values.size();
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase() && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d values outstanding", $time, expected_values.size());
      $display("elias_gamma_zigzag_decoder_top_test: done, errors");
      $finish;
    end
  end

  initial begin
    int   mode;
    int   len;
    int   zeros;
    logic mid_drain_done;
    logic [egzd_pkg::CODE_BITS-1:0] k;

    rst = 1'b1;
    mid_drain_done = 1'b0;

    // eight single-bit codes in one byte
    start_next = 1'b1;
    repeat (8) push_code(1);
    pack_bytes();
    // overlong prefix across four empty bytes
    push_bits('0, 32);
    pack_bytes();
    // extreme values, then the smallest nonzero ones, then padding
    push_code(32'hFFFF_FFFF);
    push_code(32'hFFFF_FFFE);
    push_code(2);
    push_code(3);
    pad_and_pack();
    // restart in the middle of a code
    push_bits(32'h0000_000F, 8);
    pack_bytes();
    start_next = 1'b1;
    push_bits(32'h0000_0080, 8);
    pack_bytes();

    drain_next = 1'b1;
    while (byte_queue.size() < STREAM_BYTES) begin
      if (!mid_drain_done && byte_queue.size() >= STREAM_BYTES / 2) begin
        drain_next     = 1'b1;
        mid_drain_done = 1'b1;
      end
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        if ($urandom_range(0, 5) == 0) begin
          pad_and_pack();
          start_next = 1'b1;
        end
        repeat ($urandom_range(1, 12)) begin
          len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 32);
          k   = egzd_pkg::CODE_BITS'($urandom & ((64'd1 << len) - 1))
              | (32'd1 << (len - 1));
          push_code(k);
        end
        pack_bytes();
      end else if (mode < 16) begin
        repeat ($urandom_range(1, 4)) begin
          start_next = ($urandom_range(0, 7) == 0);
          push_bits($urandom, 8);
          pack_bytes();
        end
      end else if (mode < 18) begin
        push_bits('0, $urandom_range(20, 32));
        push_bits('0, $urandom_range(0, 16));
        pack_bytes();
      end else begin
        zeros = $urandom_range(1, 20);
        push_bits('0, zeros);
        push_bits(1, 1);
        push_bits($urandom, $urandom_range(0, zeros - 1));
        pad_and_pack();
        start_next = 1'b1;
      end
    end
    pad_and_pack();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (byte_queue.size() != 0 || in_ch.valid);
    do @(posedge clk); while (expected_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d code bytes with %0d stream restarts", bytes_sent, restarts_seen);
    $display("checked %0d decoded values, %0d of them overlong prefixes",
             values_checked, overlong_seen);
    if (error_count == 0) begin
      $display("elias_gamma_zigzag_decoder_top_test: done, clean");
    end else begin
      $display("elias_gamma_zigzag_decoder_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/egzd_pkg.sv
design/egzd_if.sv
design/egzd_bit_unit.sv
design/elias_gamma_zigzag_decoder_top.sv
design/egzd_checker.sv
tb/elias_gamma_zigzag_decoder_top_test.sv
